>>> src/gsst_pkg.sv
package gsst_pkg;

   // fixed field widths of the request and response words
   localparam int ID_BITS   = 12;
   localparam int WORD_BITS = 64;
   localparam int PTR_BITS  = 16;
   localparam int CNT_BITS  = 13;

   // request codes
   localparam logic [2:0] REQ_INSERT     = 3'd0;
   localparam logic [2:0] REQ_REMOVE     = 3'd1;
   localparam logic [2:0] REQ_DESTROY    = 3'd2;
   localparam logic [2:0] REQ_LOOKUP     = 3'd3;
   localparam logic [2:0] REQ_ADD_GROUP  = 3'd4;
   localparam logic [2:0] REQ_REM_GROUP  = 3'd5;
   localparam logic [2:0] REQ_ENTITY_AT  = 3'd6;
   localparam logic [2:0] REQ_DUPLICATE  = 3'd7;

   // status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_RANGE    = 2'd1;
   localparam logic [1:0] STS_NOTFOUND = 2'd2;
   localparam logic [1:0] STS_PRESENT  = 2'd3;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [ID_BITS-1:0]   entity_id;
      logic [ID_BITS-1:0]   dest_entity_id;
      logic [ID_BITS-1:0]   dense_slot;
      logic [WORD_BITS-1:0] component_word;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 present;
      logic [ID_BITS-1:0]   slot_out;
      logic [ID_BITS-1:0]   entity_out;
      logic [WORD_BITS-1:0] data_out;
      logic [CNT_BITS-1:0]  count_out;
      logic [CNT_BITS-1:0]  group_count_out;
   } rsp_word_type;

   // sparse map access: one read and one write port
   typedef struct packed {
      logic                rd;
      logic                wr;
      logic [PTR_BITS-1:0] rd_addr;
      logic [PTR_BITS-1:0] wr_addr;
      logic                valid;
      logic [PTR_BITS-1:0] slot;
   } sparse_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [PTR_BITS-1:0] slot;
   } sparse_rd_type;

   // dense store access: one read and one write port
   typedef struct packed {
      logic                 rd;
      logic                 wr;
      logic [PTR_BITS-1:0]  rd_addr;
      logic [PTR_BITS-1:0]  wr_addr;
      logic [ID_BITS-1:0]   entity;
      logic [WORD_BITS-1:0] data;
   } dense_cmd_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   entity;
      logic [WORD_BITS-1:0] data;
   } dense_rd_type;

endpackage

>>> src/gsst_sparse_map.sv
module gsst_sparse_map #(
   parameter int MAX_IDS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gsst_pkg::sparse_cmd_type cmd,
   output gsst_pkg::sparse_rd_type  q,
   output logic                    ready
);
   localparam int IW = $clog2(MAX_IDS);

   logic [IW:0]   mem [MAX_IDS];
   logic [IW:0]   q_ff;
   logic          clr_ff, clr_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;

   // clearing pass after reset, one entry a cycle
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IW'(MAX_IDS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // memory: valid bit over slot
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr) begin
         mem[cmd.wr_addr[IW-1:0]] <= {cmd.valid, cmd.slot[IW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         q_ff <= mem[cmd.rd_addr[IW-1:0]];
      end
   end

   assign q.valid = q_ff[IW];
   assign q.slot  = gsst_pkg::PTR_BITS'(q_ff[IW-1:0]);
   assign ready   = !clr_ff;

endmodule

>>> src/gsst_dense_store.sv
module gsst_dense_store #(
   parameter int MAX_IDS   = 4096,
   parameter int DATA_BITS = 64
) (
   input  logic                    clock,
   input  gsst_pkg::dense_cmd_type  cmd,
   output gsst_pkg::dense_rd_type   q
);
   localparam int IW = $clog2(MAX_IDS);

   logic [gsst_pkg::ID_BITS-1:0] ent_mem  [MAX_IDS];
   logic [DATA_BITS-1:0]         data_mem [MAX_IDS];
   logic [gsst_pkg::ID_BITS-1:0] ent_q_ff;
   logic [DATA_BITS-1:0]         data_q_ff;

   // write port; the word is cut to DATA_BITS here
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         ent_mem[cmd.wr_addr[IW-1:0]]  <= cmd.entity;
         data_mem[cmd.wr_addr[IW-1:0]] <= cmd.data[DATA_BITS-1:0];
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         ent_q_ff  <= ent_mem[cmd.rd_addr[IW-1:0]];
         data_q_ff <= data_mem[cmd.rd_addr[IW-1:0]];
      end
   end

   assign q.entity = ent_q_ff;
   assign q.data   = gsst_pkg::WORD_BITS'(data_q_ff);

endmodule

>>> src/grouped_sparse_set_table.sv
// channel   ports                        handshake
// request   start, busy, req_word        word taken when start && !busy
// response  rsp_valid, rsp_word          word valid for one cycle, no stall
//
// Insert and index read are the quickest requests, then lookup, then duplicate;
// group moves may need one slot swap and remove up to two, each through the dense
// store port. Swaps and the second map lookup of a duplicate make the longer ones.
// Reset: after reset the sparse map is cleared one entry a cycle, MAX_IDS
// cycles, with busy high. The response strobe is never held off.
module grouped_sparse_set_table #(
   parameter int MAX_IDS   = 4096,
   parameter int DATA_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gsst_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output gsst_pkg::rsp_word_type rsp_word
);
   localparam int IW = $clog2(MAX_IDS);
   localparam int CW = $clog2(MAX_IDS + 1);
   localparam logic [16:0] MAX_V = 17'(MAX_IDS);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_LOOK    = 4'd1;
   localparam logic [3:0] ST_DREAD   = 4'd2;
   localparam logic [3:0] ST_DUPLOOK = 4'd3;
   localparam logic [3:0] ST_SW1     = 4'd4;
   localparam logic [3:0] ST_SW2     = 4'd5;
   localparam logic [3:0] ST_SW3     = 4'd6;
   localparam logic [3:0] ST_SW4     = 4'd7;
   localparam logic [3:0] ST_REM2    = 4'd8;
   localparam logic [3:0] ST_REMEND  = 4'd9;

   gsst_pkg::sparse_cmd_type sp_cmd;
   gsst_pkg::sparse_rd_type  sp_q;
   gsst_pkg::dense_cmd_type  dn_cmd;
   gsst_pkg::dense_rd_type   dn_q;
   logic                     map_ready;

   logic [3:0]                     state_ff, state_in, ret_ff, ret_in;
   gsst_pkg::req_word_type         req_ff, req_in;
   logic                           pres_ff, pres_in;
   logic [IW-1:0]                  slot_ff, slot_in;
   logic [CW-1:0]                  cnt_ff, cnt_in, gc_ff, gc_in;
   logic [1:0]                     status_ff, status_in;
   logic [IW-1:0]                  rslot_ff, rslot_in;
   logic [gsst_pkg::ID_BITS-1:0]   ent_ff, ent_in;
   logic [gsst_pkg::WORD_BITS-1:0] data_ff, data_in;
   logic [gsst_pkg::WORD_BITS-1:0] dup_ff, dup_in;
   logic [IW-1:0]                  sa_ff, sa_in, sb_ff, sb_in;
   logic [gsst_pkg::ID_BITS-1:0]   ta_ent_ff, ta_ent_in;
   logic [gsst_pkg::WORD_BITS-1:0] ta_data_ff, ta_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           e_ok, d_ok, pres;
   logic [IW-1:0]                  pslot;
   logic                           ins_go;
   logic [gsst_pkg::ID_BITS-1:0]   ins_id;
   logic                           ins_ok;
   logic [gsst_pkg::WORD_BITS-1:0] ins_word;

   gsst_sparse_map #(.MAX_IDS(MAX_IDS)) u_sparse (
      .clock (clock),
      .reset (reset),
      .cmd   (sp_cmd),
      .q     (sp_q),
      .ready (map_ready)
   );

   gsst_dense_store #(.MAX_IDS(MAX_IDS), .DATA_BITS(DATA_BITS)) u_dense (
      .clock (clock),
      .cmd   (dn_cmd),
      .q     (dn_q)
   );

   assign e_ok  = 17'(req_ff.entity_id) < MAX_V;
   assign d_ok  = 17'(req_ff.dest_entity_id) < MAX_V;
   assign pres  = e_ok && sp_q.valid;
   assign pslot = sp_q.slot[IW-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      req_in       = req_ff;
      pres_in      = pres_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      gc_in        = gc_ff;
      status_in    = status_ff;
      rslot_in     = rslot_ff;
      ent_in       = ent_ff;
      data_in      = data_ff;
      dup_in       = dup_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      ta_ent_in    = ta_ent_ff;
      ta_data_in   = ta_data_ff;
      rsp_valid_in = 1'b0;
      sp_cmd       = '0;
      dn_cmd       = '0;
      ins_go       = 1'b0;
      ins_id       = req_ff.entity_id;
      ins_ok       = e_ok;
      ins_word     = req_ff.component_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && map_ready) begin
               req_in         = req_word;
               status_in      = gsst_pkg::STS_OK;
               rslot_in       = '0;
               ent_in         = '0;
               data_in        = '0;
               sp_cmd.rd      = 1'b1;
               sp_cmd.rd_addr = gsst_pkg::PTR_BITS'(req_word.entity_id);
               dn_cmd.rd      = 1'b1;
               dn_cmd.rd_addr = gsst_pkg::PTR_BITS'(req_word.dense_slot);
               state_in       = ST_LOOK;
            end
         end
         ST_LOOK: begin
            pres_in = pres;
            slot_in = pslot;
            unique case (req_ff.req_type)
               gsst_pkg::REQ_INSERT: begin
                  ins_go = 1'b1;
               end
               gsst_pkg::REQ_REMOVE, gsst_pkg::REQ_DESTROY: begin
                  if (!pres) begin
                     if (req_ff.req_type == gsst_pkg::REQ_REMOVE) begin
                        status_in = gsst_pkg::STS_NOTFOUND;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (CW'(pslot) < gc_ff) begin
                     // move to the end of the group first
                     sa_in    = pslot;
                     sb_in    = IW'(gc_ff - 1'b1);
                     slot_in  = IW'(gc_ff - 1'b1);
                     gc_in    = gc_ff - 1'b1;
                     ret_in   = ST_REM2;
                     state_in = ST_SW1;
                  end else begin
                     state_in = ST_REM2;
                  end
               end
               gsst_pkg::REQ_LOOKUP, gsst_pkg::REQ_DUPLICATE: begin
                  if (!pres) begin
                     status_in    = gsst_pkg::STS_NOTFOUND;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     if (req_ff.req_type == gsst_pkg::REQ_LOOKUP) begin
                        rslot_in = pslot;
                     end
                     dn_cmd.rd      = 1'b1;
                     dn_cmd.rd_addr = gsst_pkg::PTR_BITS'(pslot);
                     state_in       = ST_DREAD;
                  end
               end
               gsst_pkg::REQ_ADD_GROUP: begin
                  if (!pres) begin
                     status_in    = gsst_pkg::STS_NOTFOUND;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (CW'(pslot) >= gc_ff) begin
                     sa_in    = pslot;
                     sb_in    = IW'(gc_ff);
                     rslot_in = IW'(gc_ff);
                     gc_in    = gc_ff + 1'b1;
                     ret_in   = ST_IDLE;
                     state_in = ST_SW1;
                  end else begin
                     rslot_in     = pslot;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               gsst_pkg::REQ_REM_GROUP: begin
                  if (!pres) begin
                     status_in    = gsst_pkg::STS_NOTFOUND;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (CW'(pslot) < gc_ff) begin
                     sa_in    = pslot;
                     sb_in    = IW'(gc_ff - 1'b1);
                     rslot_in = IW'(gc_ff - 1'b1);
                     gc_in    = gc_ff - 1'b1;
                     ret_in   = ST_IDLE;
                     state_in = ST_SW1;
                  end else begin
                     rslot_in     = pslot;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               gsst_pkg::REQ_ENTITY_AT: begin
                  if (17'(req_ff.dense_slot) < 17'(cnt_ff)) begin
                     ent_in = dn_q.entity;
                  end else begin
                     status_in = gsst_pkg::STS_RANGE;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DREAD: begin
            if (req_ff.req_type == gsst_pkg::REQ_LOOKUP) begin
               data_in      = dn_q.data;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // duplicate: fetch the destination's map entry
               dup_in         = dn_q.data;
               sp_cmd.rd      = 1'b1;
               sp_cmd.rd_addr = gsst_pkg::PTR_BITS'(req_ff.dest_entity_id);
               state_in       = ST_DUPLOOK;
            end
         end
         ST_DUPLOOK: begin
            ins_go   = 1'b1;
            ins_id   = req_ff.dest_entity_id;
            ins_ok   = d_ok;
            ins_word = dup_ff;
         end
         ST_SW1: begin
            if (sa_ff == sb_ff) begin
               rsp_valid_in = (ret_ff == ST_IDLE);
               state_in     = ret_ff;
            end else begin
               dn_cmd.rd      = 1'b1;
               dn_cmd.rd_addr = gsst_pkg::PTR_BITS'(sa_ff);
               state_in       = ST_SW2;
            end
         end
         ST_SW2: begin
            ta_ent_in      = dn_q.entity;
            ta_data_in     = dn_q.data;
            dn_cmd.rd      = 1'b1;
            dn_cmd.rd_addr = gsst_pkg::PTR_BITS'(sb_ff);
            state_in       = ST_SW3;
         end
         ST_SW3: begin
            // slot b's entry moves into slot a
            dn_cmd.wr      = 1'b1;
            dn_cmd.wr_addr = gsst_pkg::PTR_BITS'(sa_ff);
            dn_cmd.entity  = dn_q.entity;
            dn_cmd.data    = dn_q.data;
            sp_cmd.wr      = 1'b1;
            sp_cmd.wr_addr = gsst_pkg::PTR_BITS'(dn_q.entity);
            sp_cmd.valid   = 1'b1;
            sp_cmd.slot    = gsst_pkg::PTR_BITS'(sa_ff);
            state_in       = ST_SW4;
         end
         ST_SW4: begin
            dn_cmd.wr      = 1'b1;
            dn_cmd.wr_addr = gsst_pkg::PTR_BITS'(sb_ff);
            dn_cmd.entity  = ta_ent_ff;
            dn_cmd.data    = ta_data_ff;
            sp_cmd.wr      = 1'b1;
            sp_cmd.wr_addr = gsst_pkg::PTR_BITS'(ta_ent_ff);
            sp_cmd.valid   = 1'b1;
            sp_cmd.slot    = gsst_pkg::PTR_BITS'(sb_ff);
            rsp_valid_in   = (ret_ff == ST_IDLE);
            state_in       = ret_ff;
         end
         ST_REM2: begin
            sa_in    = slot_ff;
            sb_in    = IW'(cnt_ff - 1'b1);
            ret_in   = ST_REMEND;
            state_in = ST_SW1;
         end
         ST_REMEND: begin
            sp_cmd.wr      = 1'b1;
            sp_cmd.wr_addr = gsst_pkg::PTR_BITS'(req_ff.entity_id);
            cnt_in         = cnt_ff - 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // append step shared by insert and duplicate
      if (ins_go) begin
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
         if (!ins_ok) begin
            status_in = gsst_pkg::STS_RANGE;
         end else if (sp_q.valid) begin
            status_in = gsst_pkg::STS_PRESENT;
            rslot_in  = pslot;
         end else if (cnt_ff == CW'(MAX_IDS)) begin
            status_in = gsst_pkg::STS_RANGE;
         end else begin
            sp_cmd.wr      = 1'b1;
            sp_cmd.wr_addr = gsst_pkg::PTR_BITS'(ins_id);
            sp_cmd.valid   = 1'b1;
            sp_cmd.slot    = gsst_pkg::PTR_BITS'(cnt_ff);
            dn_cmd.wr      = 1'b1;
            dn_cmd.wr_addr = gsst_pkg::PTR_BITS'(cnt_ff);
            dn_cmd.entity  = ins_id;
            dn_cmd.data    = ins_word;
            rslot_in       = IW'(cnt_ff);
            cnt_in         = cnt_ff + 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= '0;
         gc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      pres_ff    <= pres_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      rslot_ff   <= rslot_in;
      ent_ff     <= ent_in;
      data_ff    <= data_in;
      dup_ff     <= dup_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      ta_ent_ff  <= ta_ent_in;
      ta_data_ff <= ta_data_in;
   end

   assign busy      = (state_ff != ST_IDLE) || !map_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_word                 = '0;
      rsp_word.status          = status_ff;
      rsp_word.present         = pres_ff;
      rsp_word.slot_out        = gsst_pkg::ID_BITS'(rslot_ff);
      rsp_word.entity_out      = ent_ff;
      rsp_word.data_out        = data_ff;
      rsp_word.count_out       = gsst_pkg::CNT_BITS'(cnt_ff);
      rsp_word.group_count_out = gsst_pkg::CNT_BITS'(gc_ff);
   end

   // checks
   a_group_fits: assert property (@(posedge clock) disable iff (reset)
      gc_ff <= cnt_ff) else $error("group count above entry count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_IDS)) else $error("entry count above capacity");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("response strobe held two cycles");

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_LOOK)) else $error("accepted word not looked up");

endmodule

>>> tb/sv/tb_grouped_sparse_set_table.sv
module tb_grouped_sparse_set_table;

   localparam int NUM_IDS    = 4096;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 40;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   gsst_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   gsst_pkg::rsp_word_type rsp_word;

   grouped_sparse_set_table u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   always #2 clock = ~clock;

   // shadow of the table
   bit          sh_valid [NUM_IDS];
   int unsigned sh_slot  [NUM_IDS];
   int unsigned sh_ent   [NUM_IDS];
   logic [63:0] sh_data  [NUM_IDS];
   int unsigned sh_count;
   int unsigned sh_group;

   gsst_pkg::rsp_word_type expected_rsps[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet_sender = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      error_count++;
   endtask

   function automatic void swap_entries(int unsigned a, int unsigned b);
      int unsigned te;
      logic [63:0] td;
      if (a == b) return;
      te = sh_ent[a]; sh_ent[a] = sh_ent[b]; sh_ent[b] = te;
      td = sh_data[a]; sh_data[a] = sh_data[b]; sh_data[b] = td;
      sh_slot[sh_ent[a]] = a;
      sh_slot[sh_ent[b]] = b;
   endfunction

   function automatic logic [1:0] place_entry(int unsigned e, logic [63:0] w,
                                              ref int unsigned slot);
      if (sh_valid[e]) begin
         slot = sh_slot[e];
         return gsst_pkg::STS_PRESENT;
      end
      if (sh_count >= NUM_IDS) return gsst_pkg::STS_RANGE;
      sh_valid[e] = 1'b1;
      sh_slot[e] = sh_count;
      sh_ent[sh_count] = e;
      sh_data[sh_count] = w;
      slot = sh_count;
      sh_count++;
      return gsst_pkg::STS_OK;
   endfunction

   function automatic void drop_entry(int unsigned e);
      int unsigned idx;
      idx = sh_slot[e];
      if (idx < sh_group) begin
         swap_entries(idx, sh_group - 1);
         sh_group--;
         idx = sh_group;
      end
      swap_entries(idx, sh_count - 1);
      sh_valid[e] = 1'b0;
      sh_slot[e] = 0;
      sh_count--;
   endfunction

   function automatic gsst_pkg::rsp_word_type predict_table(gsst_pkg::req_word_type r);
      gsst_pkg::rsp_word_type o;
      int unsigned e, slot;
      bit pres;
      e = 32'(r.entity_id);
      slot = 0;
      pres = sh_valid[e];
      o = '0;
      o.status = gsst_pkg::STS_OK;
      case (r.req_type)
         gsst_pkg::REQ_INSERT: o.status = place_entry(e, r.component_word, slot);
         gsst_pkg::REQ_REMOVE: begin
            if (pres) drop_entry(e);
            else o.status = gsst_pkg::STS_NOTFOUND;
         end
         gsst_pkg::REQ_DESTROY: if (pres) drop_entry(e);
         gsst_pkg::REQ_LOOKUP: begin
            if (pres) begin
               slot = sh_slot[e];
               o.data_out = sh_data[slot];
            end else o.status = gsst_pkg::STS_NOTFOUND;
         end
         gsst_pkg::REQ_ADD_GROUP: begin
            if (!pres) o.status = gsst_pkg::STS_NOTFOUND;
            else begin
               slot = sh_slot[e];
               if (slot >= sh_group) begin
                  swap_entries(slot, sh_group);
                  sh_group++;
                  slot = sh_slot[e];
               end
            end
         end
         gsst_pkg::REQ_REM_GROUP: begin
            if (!pres) o.status = gsst_pkg::STS_NOTFOUND;
            else begin
               slot = sh_slot[e];
               if (slot < sh_group) begin
                  sh_group--;
                  swap_entries(slot, sh_group);
                  slot = sh_slot[e];
               end
            end
         end
         gsst_pkg::REQ_ENTITY_AT: begin
            if (32'(r.dense_slot) < sh_count) o.entity_out = 12'(sh_ent[r.dense_slot]);
            else o.status = gsst_pkg::STS_RANGE;
         end
         default: begin
            if (!pres) o.status = gsst_pkg::STS_NOTFOUND;
            else o.status = place_entry(32'(r.dest_entity_id), sh_data[sh_slot[e]], slot);
         end
      endcase
      o.present = pres;
      o.slot_out = slot[11:0];
      o.count_out = sh_count[12:0];
      o.group_count_out = sh_group[12:0];
      return o;
   endfunction

   // send one word; a random gap before it unless idling is off
   task automatic send_word(input gsst_pkg::req_word_type r);
      while (!quiet_sender && $urandom_range(99) < 17) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      expected_rsps.insert(expected_rsps.size(), predict_table(r));
   endtask

   task automatic send_op(input logic [2:0] op, input int e, input int d = 0,
                          input int ds = 0, input logic [63:0] w = '0);
      gsst_pkg::req_word_type r;
      r.req_type = op;
      r.entity_id = 12'(e);
      r.dest_entity_id = 12'(d);
      r.dense_slot = 12'(ds);
      r.component_word = w;
      send_word(r);
   endtask

   // response checker
   always @(posedge clock) begin
      gsst_pkg::rsp_word_type x;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response word", '0, '0);
         end else begin
            x = expected_rsps.pop_front();
            if (rsp_word.status !== x.status)
               report_mismatch("status", 64'(rsp_word.status), 64'(x.status));
            if (rsp_word.present !== x.present)
               report_mismatch("present", 64'(rsp_word.present), 64'(x.present));
            if (rsp_word.slot_out !== x.slot_out)
               report_mismatch("slot_out", 64'(rsp_word.slot_out), 64'(x.slot_out));
            if (rsp_word.entity_out !== x.entity_out)
               report_mismatch("entity_out", 64'(rsp_word.entity_out),
                               64'(x.entity_out));
            if (rsp_word.data_out !== x.data_out)
               report_mismatch("data_out", rsp_word.data_out, x.data_out);
            if (rsp_word.count_out !== x.count_out)
               report_mismatch("count_out", 64'(rsp_word.count_out),
                               64'(x.count_out));
            if (rsp_word.group_count_out !== x.group_count_out)
               report_mismatch("group_count_out", 64'(rsp_word.group_count_out),
                               64'(x.group_count_out));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      send_op(gsst_pkg::REQ_LOOKUP, 0);
      send_op(gsst_pkg::REQ_REMOVE, 4095);
      send_op(gsst_pkg::REQ_DESTROY, 5);
      send_op(gsst_pkg::REQ_ENTITY_AT, 0, 0, 0);
      send_op(gsst_pkg::REQ_INSERT, 0, 0, 0, '1);
      send_op(gsst_pkg::REQ_INSERT, 4095, 0, 0, 64'h0);
      send_op(gsst_pkg::REQ_INSERT, 4095, 0, 0, 64'h5a5a);
      send_op(gsst_pkg::REQ_INSERT, 100, 0, 0, 64'h8000_0000_0000_0001);
      send_op(gsst_pkg::REQ_LOOKUP, 0);
      send_op(gsst_pkg::REQ_LOOKUP, 4095);
      send_op(gsst_pkg::REQ_ENTITY_AT, 0, 0, 2);
      send_op(gsst_pkg::REQ_ENTITY_AT, 0, 0, 3);
      send_op(gsst_pkg::REQ_ENTITY_AT, 0, 0, 4095);
      send_op(gsst_pkg::REQ_ADD_GROUP, 100);
      send_op(gsst_pkg::REQ_ADD_GROUP, 100);
      send_op(gsst_pkg::REQ_ADD_GROUP, 4095);
      send_op(gsst_pkg::REQ_REM_GROUP, 0);
      send_op(gsst_pkg::REQ_ADD_GROUP, 7);
      send_op(gsst_pkg::REQ_DUPLICATE, 0, 4094);
      send_op(gsst_pkg::REQ_DUPLICATE, 0, 4095);
      send_op(gsst_pkg::REQ_DUPLICATE, 9, 10);
      send_op(gsst_pkg::REQ_REMOVE, 100);
      send_op(gsst_pkg::REQ_REM_GROUP, 4095);
      send_op(gsst_pkg::REQ_DESTROY, 0);
      send_op(gsst_pkg::REQ_LOOKUP, 4094);
   endtask

   // ids drawn mostly from a small pool so that hits are common
   function automatic int pick_id();
      if ($urandom_range(9) < 8) return $urandom_range(47);
      return $urandom_range(4095);
   endfunction

   task automatic test_random(input int n);
      gsst_pkg::req_word_type r;
      for (int i = 0; i < n; i++) begin
         quiet_sender = (i >= n / 2) && (i < n / 2 + 150);
         r.req_type = 3'($urandom_range(7));
         r.entity_id = 12'(pick_id());
         r.dest_entity_id = 12'(pick_id());
         r.dense_slot = 12'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                     : $urandom_range(63));
         r.component_word = {$urandom, $urandom};
         if (r.req_type == gsst_pkg::REQ_INSERT && $urandom_range(3) == 0)
            r.req_type = gsst_pkg::REQ_INSERT;
         send_word(r);
      end
      quiet_sender = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NUM_IDS; i++) begin
         sh_valid[i] = 1'b0; sh_slot[i] = 0; sh_ent[i] = 0; sh_data[i] = '0;
      end
      sh_count = 0;
      sh_group = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1275);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
